[rtl/mtu_pkg.sv]
// Shared types and constants of the 4x4 transform matrix unit.
package mtu_pkg;

  localparam int unsigned NUM_ELEMS = 16;
  localparam int unsigned COEF_W    = 32;

  typedef enum logic [2:0] {
    OP_IDENT     = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_TRANSLATE = 3'd3,
    OP_SCALE     = 3'd4,
    OP_ROTX      = 3'd5,
    OP_ROTY      = 3'd6,
    OP_ROTZ      = 3'd7
  } op_e;

  typedef logic [3:0] elem_idx_t;

  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    logic      clr;
    elem_idx_t rd_addr;
    elem_idx_t wr_addr;
  } mem_cmd_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[rtl/mtu_mem.sv]
// Matrix element store: one synchronous write port, one registered read port, valid bits.
module mtu_mem #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mtu_pkg::mem_cmd_t      cmd_i,
  input  logic [WORD_BITS-1:0]   wr_data_i,
  output logic [WORD_BITS-1:0]   rd_data_o
);
  import mtu_pkg::*;

  logic [WORD_BITS-1:0] mem_q [NUM_ELEMS];
  logic [NUM_ELEMS-1:0] valid_q, valid_d;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clr) begin
      valid_d = '0;
    end
    if (cmd_i.wr_en) begin
      valid_d[cmd_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.rd_en) begin
        rvalid_q <= valid_q[cmd_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/mtu_mac.sv]
// Shared multiply, shift, accumulate and saturate unit, three stages.
module mtu_mac #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtu_pkg::mac_ctl_t              ctl_i,
  input  logic [WORD_BITS-1:0]           a_i,
  input  logic [mtu_pkg::COEF_W-1:0]     b_i,
  output logic                           res_valid_o,
  output logic [WORD_BITS-1:0]           res_o
);
  import mtu_pkg::*;

  localparam int unsigned PW = WORD_BITS + COEF_W;
  localparam int unsigned SW = PW - FRAC_BITS;
  localparam int unsigned AW = SW + 2;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  mac_ctl_t               ctl1_q, ctl2_q;
  logic signed [PW-1:0]   prod_q;
  logic        [AW-1:0]   acc_q, acc_d, acc_base, term;
  logic                   fits;
  logic [WORD_BITS-1:0]   sat;
  logic [WORD_BITS-1:0]   res_q;
  logic                   res_valid_q;

  always_comb begin
    term     = AW'($signed(prod_q[PW-1:FRAC_BITS]));
    acc_base = ctl1_q.first ? '0 : acc_q;
    acc_d    = acc_base + term;
    fits     = (acc_q[AW-1:WORD_BITS-1] == '0) || (acc_q[AW-1:WORD_BITS-1] == '1);
    sat      = fits ? acc_q[WORD_BITS-1:0] : (acc_q[AW-1] ? WMIN : WMAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ctl1_q      <= ctl_i;
      ctl2_q      <= ctl1_q;
      res_valid_q <= ctl2_q.valid && ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'($signed(a_i)) * PW'($signed(b_i));
    if (ctl1_q.valid) begin
      acc_q <= acc_d;
    end
    res_q <= sat;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/mtu_ctrl.sv]
// Operation sequencer: item capture, row buffer, coefficient select, memory and MAC control.
module mtu_ctrl #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [3:0]                  elem_index_i,
  input  logic signed [31:0]          elem_value_i,
  input  logic signed [31:0]          arg_x_i,
  input  logic signed [31:0]          arg_y_i,
  input  logic signed [31:0]          arg_z_i,
  input  logic signed [17:0]          sine_val_i,
  input  logic signed [17:0]          cosine_val_i,
  output mtu_pkg::mem_cmd_t           mem_cmd_o,
  output logic [WORD_BITS-1:0]        mem_wr_data_o,
  input  logic [WORD_BITS-1:0]        mem_rd_data_i,
  output mtu_pkg::mac_ctl_t           mac_ctl_o,
  output logic [WORD_BITS-1:0]        mac_a_o,
  output logic [mtu_pkg::COEF_W-1:0]  mac_b_o,
  input  logic                        mac_res_valid_i,
  input  logic [WORD_BITS-1:0]        mac_res_i,
  input  logic                        out_free_i,
  output logic                        done_o,
  output logic [31:0]                 result_o
);
  import mtu_pkg::*;

  localparam logic [COEF_W-1:0]    ONE_B = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic [WORD_BITS-1:0] WMAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] ONE_W = (FRAC_BITS + 2 <= WORD_BITS) ?
                                           WORD_BITS'(64'd1 << FRAC_BITS) : WMAX;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDENT,
    S_WRITE,
    S_READ,
    S_READW,
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [3:0]           cnt_q;
  logic [1:0]           r_q;
  logic [1:0]           wcnt_q;
  logic                 rd_pend_q;
  logic [1:0]           rd_k_q;
  logic [31:0]          result_q;

  op_e                  op_q;
  elem_idx_t            idx_q;
  logic signed [31:0]   val_q, x_q, y_q, z_q;
  logic signed [17:0]   s_q, c_q;
  logic [WORD_BITS-1:0] rowbuf_q [4];

  logic                 is_scale;
  logic                 load_last, mac_last, wr_last;
  logic [COEF_W-1:0]    sx, cx, nsx, coef;
  logic [63:0]          v64, r64;
  logic                 wfits;
  logic [WORD_BITS-1:0] wsat;

  assign is_scale  = (op_q == OP_SCALE);
  assign load_last = is_scale ? (cnt_q == 4'd2) : (cnt_q == 4'd3);
  assign mac_last  = is_scale ? (cnt_q == 4'd2) : (cnt_q == 4'd15);
  assign wr_last   = is_scale ? (wcnt_q == 2'd2) : (wcnt_q == 2'd3);

  assign sx  = COEF_W'(s_q);
  assign cx  = COEF_W'(c_q);
  assign nsx = '0 - sx;

  assign v64   = 64'(val_q);
  assign wfits = (v64[63:WORD_BITS-1] == '0) || (v64[63:WORD_BITS-1] == '1);
  assign wsat  = wfits ? v64[WORD_BITS-1:0] : (v64[63] ? WMIN : WMAX);
  assign r64   = 64'($signed(mem_rd_data_i));

  always_comb begin
    coef = '0;
    unique case (op_q)
      OP_TRANSLATE: begin
        unique case (cnt_q)
          4'd0, 4'd5, 4'd10, 4'd15: coef = ONE_B;
          4'd12:                    coef = x_q;
          4'd13:                    coef = y_q;
          4'd14:                    coef = z_q;
          default:                  coef = '0;
        endcase
      end
      OP_ROTX: begin
        unique case (cnt_q)
          4'd0, 4'd15: coef = ONE_B;
          4'd5, 4'd10: coef = cx;
          4'd6:        coef = nsx;
          4'd9:        coef = sx;
          default:     coef = '0;
        endcase
      end
      OP_ROTY: begin
        unique case (cnt_q)
          4'd5, 4'd15: coef = ONE_B;
          4'd0, 4'd10: coef = cx;
          4'd2:        coef = sx;
          4'd8:        coef = nsx;
          default:     coef = '0;
        endcase
      end
      OP_ROTZ: begin
        unique case (cnt_q)
          4'd10, 4'd15: coef = ONE_B;
          4'd0, 4'd5:   coef = cx;
          4'd1:         coef = nsx;
          4'd4:         coef = sx;
          default:      coef = '0;
        endcase
      end
      OP_SCALE: begin
        unique case (cnt_q[1:0])
          2'd0:    coef = x_q;
          2'd1:    coef = y_q;
          default: coef = z_q;
        endcase
      end
      default: coef = '0;
    endcase
  end

  always_comb begin
    mem_cmd_o     = '0;
    mem_wr_data_o = '0;
    unique case (state_q)
      S_IDENT: begin
        mem_cmd_o.wr_en   = 1'b1;
        mem_cmd_o.clr     = (cnt_q == 4'd0);
        mem_cmd_o.wr_addr = {cnt_q[1:0], cnt_q[1:0]};
        mem_wr_data_o     = ONE_W;
      end
      S_WRITE: begin
        mem_cmd_o.wr_en   = 1'b1;
        mem_cmd_o.wr_addr = idx_q;
        mem_wr_data_o     = wsat;
      end
      S_READ: begin
        mem_cmd_o.rd_en   = 1'b1;
        mem_cmd_o.rd_addr = idx_q;
      end
      S_LOAD: begin
        mem_cmd_o.rd_en   = 1'b1;
        mem_cmd_o.rd_addr = is_scale ? {cnt_q[1:0], cnt_q[1:0]} : {cnt_q[1:0], r_q};
      end
      default: begin
        mem_cmd_o = '0;
      end
    endcase
    if (mac_res_valid_i) begin
      mem_cmd_o.wr_en   = 1'b1;
      mem_cmd_o.wr_addr = is_scale ? {wcnt_q, wcnt_q} : {wcnt_q, r_q};
      mem_wr_data_o     = mac_res_i;
    end
  end

  assign mac_ctl_o.valid = (state_q == S_MAC);
  assign mac_ctl_o.first = is_scale || (cnt_q[1:0] == 2'd0);
  assign mac_ctl_o.last  = is_scale || (cnt_q[1:0] == 2'd3);
  assign mac_a_o         = rowbuf_q[cnt_q[1:0]];
  assign mac_b_o         = coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      r_q       <= '0;
      wcnt_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_k_q    <= '0;
      result_q  <= '0;
    end else begin
      rd_pend_q <= (state_q == S_LOAD);
      rd_k_q    <= cnt_q[1:0];
      if (mac_res_valid_i) begin
        wcnt_q <= wcnt_q + 2'd1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            result_q <= '0;
            cnt_q    <= '0;
            r_q      <= '0;
            wcnt_q   <= '0;
            unique case (op_e'(op_i))
              OP_IDENT: state_q <= S_IDENT;
              OP_WRITE: state_q <= S_WRITE;
              OP_READ:  state_q <= S_READ;
              OP_TRANSLATE, OP_SCALE, OP_ROTX, OP_ROTY, OP_ROTZ: state_q <= S_LOAD;
            endcase
          end
        end
        S_IDENT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            state_q <= S_DONE;
          end
        end
        S_WRITE: state_q <= S_DONE;
        S_READ:  state_q <= S_READW;
        S_READW: begin
          result_q <= r64[31:0];
          state_q  <= S_DONE;
        end
        S_LOAD: begin
          if (load_last) begin
            cnt_q   <= '0;
            state_q <= S_MAC;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_MAC: begin
          cnt_q <= cnt_q + 4'd1;
          if (mac_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_res_valid_i && wr_last) begin
            if (is_scale || (r_q == 2'd3)) begin
              state_q <= S_DONE;
            end else begin
              r_q     <= r_q + 2'd1;
              cnt_q   <= '0;
              state_q <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_e'(op_i);
      idx_q <= elem_index_i;
      val_q <= elem_value_i;
      x_q   <= arg_x_i;
      y_q   <= arg_y_i;
      z_q   <= arg_z_i;
      s_q   <= sine_val_i;
      c_q   <= cosine_val_i;
    end
    if (rd_pend_q) begin
      rowbuf_q[rd_k_q] <= mem_rd_data_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign result_o   = result_q;

endmodule

[rtl/matrix4x4_transform_unit.sv]
// Top level of the 4x4 transform matrix unit: sequencer, element store, MAC unit, output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | op, elem_index, elem_value, arg_x/y/z,
//           |           |                          | sine_val, cosine_val
//   out     | output    | out_valid_o / out_ready_i| read_value
//
// One item at a time. Translate and rotate run four rows of 4 element reads, 16 MACs
// through the shared three-stage multiplier and a drain of the row's results.
// Reset clears the element valid bits, so all elements read as zero; no clearing sweep.
// A result waits in the output register; the next item is taken meanwhile, and its own
// result holds in the sequencer until the register frees.
module matrix4x4_transform_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] arg_x_i,
  input  logic signed [31:0] arg_y_i,
  input  logic signed [31:0] arg_z_i,
  input  logic signed [17:0] sine_val_i,
  input  logic signed [17:0] cosine_val_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o
);
  import mtu_pkg::*;

  mem_cmd_t             mem_cmd;
  logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;
  mac_ctl_t             mac_ctl;
  logic [WORD_BITS-1:0] mac_a, mac_res;
  logic [COEF_W-1:0]    mac_b;
  logic                 mac_res_valid;
  logic                 done, out_free;
  logic [31:0]          result;
  logic                 out_valid_q;
  logic [31:0]          read_value_q;

  mtu_ctrl #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .elem_index_i    (elem_index_i),
    .elem_value_i    (elem_value_i),
    .arg_x_i         (arg_x_i),
    .arg_y_i         (arg_y_i),
    .arg_z_i         (arg_z_i),
    .sine_val_i      (sine_val_i),
    .cosine_val_i    (cosine_val_i),
    .mem_cmd_o       (mem_cmd),
    .mem_wr_data_o   (mem_wr_data),
    .mem_rd_data_i   (mem_rd_data),
    .mac_ctl_o       (mac_ctl),
    .mac_a_o         (mac_a),
    .mac_b_o         (mac_b),
    .mac_res_valid_i (mac_res_valid),
    .mac_res_i       (mac_res),
    .out_free_i      (out_free),
    .done_o          (done),
    .result_o        (result)
  );

  mtu_mem #(
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  mtu_mac #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mac_ctl),
    .a_i         (mac_a),
    .b_i         (mac_b),
    .res_valid_o (mac_res_valid),
    .res_o       (mac_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      read_value_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

  a_mac_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_res_valid |-> !in_ready_o)
    else $error("MAC result while sequencer idle");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !out_free |=> done)
    else $error("result dropped while output register full");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer not busy after input transfer");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(done))
    else $error("output valid without finished item");

endmodule
